// File: src/vdf_pkg.sv
// vdf_pkg: beat types, request codes and controller states of the value
// domain filter. No dependencies; every module of the block imports it.
package vdf_pkg;

    localparam int VALUE_W = 64;
    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_PROBE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_FILL  = 2'd3
    } t_req_e;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_POS,
        S_ADD_WR,
        S_SCAN,
        S_SUM,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } t_state_e;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic               could_qualify;
        logic [VALUE_W-1:0] next_value;
        logic               found;
        logic [VALUE_W-1:0] lower_bound;
        logic [VALUE_W-1:0] upper_bound;
    } t_out_beat;

endpackage

// File: src/value_domain_filter.sv
// value_domain_filter: bounds plus hashed presence bitmap over 64-bit values.
// Depends on vdf_pkg, vdf_bitpos and vdf_ram.
//
// Usage: one input channel (i_in_valid/o_in_ready, payload i_in) carries
// add, probe, clear and fill requests; one output channel
// (o_out_valid/i_out_ready, payload o_out) returns exactly one result beat
// per request, in order. Items are worked one at a time; the bitmap lives
// in a single RAM with registered read data.
// Steps per request, with M = MAP_WORDS; the bit is located iteratively
// when M*WORD_BITS is not a power of two:
//   add        locate the bit, read its word, write it back with the bit set
//   probe      locate the bit, scan one bitmap word per cycle over up to
//              M + 1 words, then add the distance and check the upper bound
//   clear/fill write one word per cycle over all M words
// A new request is taken in the cycle after the previous result is handed to
// the output register, so a stalled receiver holds at most one result and
// the next request still goes ahead; it stalls at that next result.
// After reset the block sweeps all M bitmap words to zero with
// o_in_ready low; bounds reset to the empty domain at once.
module value_domain_filter
    import vdf_pkg::*;
#(
    parameter int MAP_WORDS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int SLOT_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFS_W  = $clog2(WORD_BITS);
    localparam int KW     = $clog2(MAP_WORDS + 2);
    localparam int DIST_W = $clog2((MAP_WORDS + 1) * WORD_BITS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAP_WORDS - 1);
    localparam logic [KW-1:0]     K_LAST    = KW'(MAP_WORDS);
    localparam logic [DIST_W-1:0] W_STEP    = DIST_W'(WORD_BITS);

    t_state_e           r_state, n_state;
    logic [1:0]         r_req;
    logic [VALUE_W-1:0] r_low, r_high, r_cval;
    logic               r_below;
    logic [SLOT_W-1:0]  r_addr;
    logic               r_sweep_ones;
    logic [KW-1:0]      r_iss_k, r_dat_k;
    logic [DIST_W-1:0]  r_iss_base, r_dat_base, r_dist;
    logic               r_dat_vld;
    logic [VALUE_W:0]   r_sum;
    logic               r_qual, r_found;
    logic [VALUE_W-1:0] r_next;
    t_out_beat          r_out;
    logic               r_out_valid;

    logic               acc, in_below, in_above, pos_start, pos_done, over, out_free;
    logic [VALUE_W-1:0] pos_value;
    logic [SLOT_W-1:0]  pos_slot;
    logic [OFS_W-1:0]   pos_ofs;

    logic                 ram_we, ram_re;
    logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                 scan_more, scan_hit;
    logic [WORD_BITS-1:0] scan_below, scan_bits;
    logic [OFS_W-1:0]     scan_p;
    logic [DIST_W-1:0]    scan_dist;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign in_below   = i_in.value < r_low;
    assign in_above   = i_in.value > r_high;
    // Clamp a probe to the lower bound before locating its bit.
    assign pos_value  = (i_in.req_type == REQ_PROBE && in_below) ? r_low : i_in.value;
    assign pos_start  = acc && (i_in.req_type == REQ_ADD || i_in.req_type == REQ_PROBE);
    assign over       = r_cval > r_high;
    assign out_free   = !r_out_valid || i_out_ready;

    vdf_bitpos #(
        .MAP_WORDS(MAP_WORDS),
        .WORD_BITS(WORD_BITS)
    ) u_bitpos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(pos_start),
        .i_value(pos_value),
        .o_done (pos_done),
        .o_slot (pos_slot),
        .o_ofs  (pos_ofs)
    );

    vdf_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Scan datapath: mask the first word from the offset up, the wrapped
    // last word below the offset, then take the lowest set bit.
    assign scan_more  = r_iss_k <= K_LAST;
    assign scan_below = ~({WORD_BITS{1'b1}} << pos_ofs);

    always_comb begin
        scan_bits = ram_rdata;
        if (r_dat_k == '0) begin
            scan_bits = scan_bits & ~scan_below;
        end
        if (r_dat_k == K_LAST) begin
            scan_bits = scan_bits & scan_below;
        end
    end

    assign scan_hit = r_dat_vld && (|scan_bits);

    always_comb begin
        scan_p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (scan_bits[i]) begin
                scan_p = OFS_W'(i);
            end
        end
    end

    assign scan_dist = r_dat_base + DIST_W'(scan_p) - DIST_W'(pos_ofs);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_addr == LAST_SLOT) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_in.req_type)
                        REQ_ADD, REQ_PROBE: n_state = S_POS;
                        default:            n_state = S_SWEEP;
                    endcase
                end
            end
            S_POS: begin
                if (pos_done) begin
                    if (r_req == REQ_ADD) n_state = S_ADD_WR;
                    else if (over)        n_state = S_DONE;
                    else                  n_state = S_SCAN;
                end
            end
            S_ADD_WR: n_state = S_DONE;
            S_SCAN: begin
                if (scan_hit)                              n_state = S_SUM;
                else if (r_dat_vld && r_dat_k == K_LAST)   n_state = S_DONE;
            end
            S_SUM:   n_state = S_CHECK;
            S_CHECK: n_state = S_DONE;
            S_SWEEP: begin
                if (r_addr == LAST_SLOT) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory controls per state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        case (r_state)
            S_INIT, S_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = r_sweep_ones ? {WORD_BITS{1'b1}} : '0;
            end
            S_POS: begin
                if (pos_done && r_req == REQ_ADD) begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_slot;
                end
            end
            S_ADD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = pos_slot;
                ram_wdata = ram_rdata | (WORD_BITS'(1) << pos_ofs);
            end
            S_SCAN: begin
                ram_re = scan_more;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_addr       <= '0;
            r_sweep_ones <= 1'b0;
            r_low        <= ALL_ONES;
            r_high       <= '0;
            r_out_valid  <= 1'b0;
            r_dat_vld    <= 1'b0;
            r_iss_k      <= '0;
        end else begin
            r_state   <= n_state;
            r_dat_vld <= (r_state == S_SCAN) && scan_more;
            case (r_state)
                S_INIT, S_SWEEP: begin
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (acc) begin
                        case (i_in.req_type)
                            REQ_ADD: begin
                                if (in_below) r_low  <= i_in.value;
                                if (in_above) r_high <= i_in.value;
                            end
                            REQ_CLEAR: begin
                                r_low        <= ALL_ONES;
                                r_high       <= '0;
                                r_addr       <= '0;
                                r_sweep_ones <= 1'b0;
                            end
                            REQ_FILL: begin
                                r_low        <= '0;
                                r_high       <= ALL_ONES;
                                r_addr       <= '0;
                                r_sweep_ones <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_POS: begin
                    r_addr  <= pos_slot;
                    r_iss_k <= '0;
                end
                S_SCAN: begin
                    if (scan_more) begin
                        r_addr  <= (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
                        r_iss_k <= r_iss_k + 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_req   <= i_in.req_type;
                    r_cval  <= pos_value;
                    r_below <= in_below;
                    r_qual  <= 1'b0;
                    r_found <= 1'b0;
                    r_next  <= '0;
                end
            end
            S_POS: begin
                r_iss_base <= '0;
                if (pos_done && r_req == REQ_PROBE && over) begin
                    r_next <= ALL_ONES;
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    r_iss_base <= r_iss_base + W_STEP;
                end
                r_dat_k    <= r_iss_k;
                r_dat_base <= r_iss_base;
                if (r_dat_vld && r_dat_k == '0) begin
                    r_qual <= !r_below && ram_rdata[pos_ofs];
                end
                if (scan_hit) begin
                    r_dist <= scan_dist;
                end else if (r_dat_vld && r_dat_k == K_LAST) begin
                    r_next <= ALL_ONES;
                end
            end
            S_SUM: begin
                r_sum <= {1'b0, r_cval} + (VALUE_W+1)'(r_dist);
            end
            S_CHECK: begin
                // Drop candidates that overflow or pass the upper bound.
                if (!r_sum[VALUE_W] && r_sum[VALUE_W-1:0] <= r_high) begin
                    r_next  <= r_sum[VALUE_W-1:0];
                    r_found <= 1'b1;
                end else begin
                    r_next <= ALL_ONES;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.could_qualify <= r_qual;
                    r_out.next_value    <= r_next;
                    r_out.found         <= r_found;
                    r_out.lower_bound   <= r_low;
                    r_out.upper_bound   <= r_high;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_pos_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_done |-> (r_state == S_POS))
        else $error("bit position ready outside its wait state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_iss_k <= KW'(MAP_WORDS + 1)))
        else $error("scan ran past the wrapped word");

    a_found_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> (r_next <= r_high && r_next >= r_low))
        else $error("candidate outside the bounds");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_POS) |-> !ram_we)
        else $error("bitmap written during a probe");

    a_out_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.found) |-> (o_out.next_value >= o_out.lower_bound))
        else $error("result candidate below the lower bound");
`endif

endmodule

// File: src/vdf_ram.sv
// vdf_ram: generic single-write, single-read memory with registered read data.
// Uses vdf_pkg for nothing but house consistency of the project.
module vdf_ram
    import vdf_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vdf_bitpos.sv
// vdf_bitpos: splits a 64-bit value into bitmap word index and bit offset
// (value mod MAP_WORDS*WORD_BITS). Depends on vdf_pkg for VALUE_W.
module vdf_bitpos
    import vdf_pkg::*;
#(
    parameter int MAP_WORDS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_W-1:0]           i_value,
    output logic                         o_done,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] o_slot,
    output logic [$clog2(WORD_BITS)-1:0] o_ofs
);

    localparam int SLOT_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFS_W  = $clog2(WORD_BITS);
    localparam bit POW2   = ((1 << $clog2(MAP_WORDS)) == MAP_WORDS) &&
                            ((1 << OFS_W) == WORD_BITS);
    localparam int DIGIT_BITS = 4;
    localparam int N_STEPS    = VALUE_W / DIGIT_BITS;
    localparam int CNT_W      = $clog2(N_STEPS);

    logic              r_done;
    logic [SLOT_W-1:0] r_slot;
    logic [OFS_W-1:0]  r_ofs;

    generate
        if (POW2) begin : g_slice
            localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(MAP_WORDS - 1);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_slot <= SLOT_W'(i_value >> OFS_W) & SLOT_MASK;
                    r_ofs  <= i_value[OFS_W-1:0];
                end
            end
        end else begin : g_iter
            logic               r_busy;
            logic [CNT_W-1:0]   r_cnt;
            logic [VALUE_W-1:0] r_shift;
            logic [SLOT_W-1:0]  n_slot;
            logic [OFS_W-1:0]   n_ofs;

            // Restoring remainder, four value bits per cycle, MSB first.
            always_comb begin
                logic [OFS_W:0]  o2;
                logic [SLOT_W:0] s2;
                logic            carry;
                n_slot = r_slot;
                n_ofs  = r_ofs;
                for (int j = 0; j < DIGIT_BITS; j++) begin
                    o2    = {n_ofs, r_shift[VALUE_W-1-j]};
                    carry = 1'b0;
                    if (o2 >= (OFS_W+1)'(WORD_BITS)) begin
                        o2    = o2 - (OFS_W+1)'(WORD_BITS);
                        carry = 1'b1;
                    end
                    s2 = {n_slot, carry};
                    if (s2 >= (SLOT_W+1)'(MAP_WORDS)) begin
                        s2 = s2 - (SLOT_W+1)'(MAP_WORDS);
                    end
                    n_ofs  = o2[OFS_W-1:0];
                    n_slot = s2[SLOT_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(N_STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                if (i_start) begin
                    r_shift <= i_value;
                    r_slot  <= '0;
                    r_ofs   <= '0;
                end else if (r_busy) begin
                    r_shift <= r_shift << DIGIT_BITS;
                    r_slot  <= n_slot;
                    r_ofs   <= n_ofs;
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_slot = r_slot;
    assign o_ofs  = r_ofs;

endmodule
